// ===== rtl/qs_pkg.sv =====
// Package for the quicksort block: field widths, counter limits and the
// command/status structs between controller and datapath. No dependencies.
package qs_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int VALUE_W          = 32;
   localparam int CMP_W            = 16;
   localparam int MOV_W            = 12;

   localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};
   localparam logic [MOV_W-1:0] MOV_MAX = {MOV_W{1'b1}};

   typedef struct packed {
      logic load_wr;
      logic sort_init;
      logic pop;
      logic pop_take;
      logic piv_take;
      logic rd_j;
      logic rd_k;
      logic i_inc;
      logic j_dec;
      logic cmp_bump;
      logic take_a;
      logic take_b;
      logic wr_swap_i;
      logic wr_swap_j;
      logic mov_bump;
      logic fin_wr_low;
      logic fin_wr_j;
      logic push_r;
      logic push_l;
      logic out_load;
      logic k_inc;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic sp_zero;
      logic i_le_j;
      logic i_le_hi;
      logic j_ge_lo;
      logic le_pivot;
      logic i_lt_j;
      logic lo_lt_j;
      logic push_r_ok;
      logic push_l_ok;
      logic final_out;
   } status_type;

endpackage

// ===== rtl/qs_chan_if.sv =====
// Handshake channels of the quicksort block: request and response.
// Depends on qs_pkg for field widths.
interface qs_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [qs_pkg::VALUE_W-1:0] value;
   logic                             last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface qs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [qs_pkg::VALUE_W-1:0] sorted_value;
   logic [qs_pkg::CMP_W-1:0]          compare_count;
   logic [qs_pkg::MOV_W-1:0]          move_count;
   logic                             final_res;

   modport source (output valid, output sorted_value, output compare_count,
                   output move_count, output final_res, input ready);
   modport sink   (input valid, input sorted_value, input compare_count,
                   input move_count, input final_res, output ready);
endinterface

// ===== rtl/qs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/qs_dp.sv =====
// Datapath of the quicksort block: element store, range stack, scan indexes,
// counters and the response register. Depends on qs_pkg and qs_ram.
module qs_dp #(
   parameter int CAPACITY = qs_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  qs_pkg::cmd_type                   cmd,
   output qs_pkg::status_type                status,
   input  logic signed [qs_pkg::VALUE_W-1:0] req_value,
   output logic signed [qs_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic [qs_pkg::CMP_W-1:0]          rsp_compare_count,
   output logic [qs_pkg::MOV_W-1:0]          rsp_move_count,
   output logic                              rsp_final_res
);
   import qs_pkg::*;

   localparam int IW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int PW    = IW + 2;
   localparam int DEPTH = CAPACITY + 2;
   localparam int SAW   = $clog2(DEPTH);
   localparam int SW    = $clog2(DEPTH + 1);

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [SW-1:0]          sp_ff, sp_in;
   logic [IW-1:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic signed [PW-1:0]   i_ff, i_in, j_ff, j_in;
   logic signed [VALUE_W-1:0] pivot_ff, pivot_in, a_ff, a_in, b_ff, b_in;
   logic [CMP_W-1:0]       cmp_ff, cmp_in;
   logic [MOV_W-1:0]       mov_ff, mov_in;
   logic signed [VALUE_W-1:0] sorted_ff, sorted_in;
   logic                   final_ff, final_in;

   logic                   st_we;
   logic [IW-1:0]          st_waddr, st_raddr;
   logic signed [VALUE_W-1:0] st_wdata, st_rdata;
   logic                   sk_we;
   logic [SAW-1:0]         sk_waddr, sk_raddr;
   logic [2*IW-1:0]        sk_wdata, sk_rdata;

   logic signed [PW-1:0]   lo_s, hi_s, j_p1, j_m1;
   logic [SW-1:0]          sp_m1;

   assign lo_s  = signed'({{(PW-IW){1'b0}}, lo_ff});
   assign hi_s  = signed'({{(PW-IW){1'b0}}, hi_ff});
   assign j_p1  = j_ff + PW'(1);
   assign j_m1  = j_ff - PW'(1);
   assign sp_m1 = sp_ff - SW'(1);

   qs_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   qs_ram #(.WIDTH(2*IW), .DEPTH(DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sk_waddr),
      .wr_data (sk_wdata),
      .rd_addr (sk_raddr),
      .rd_data (sk_rdata)
   );

   always_comb begin
      st_we    = 1'b0;
      st_waddr = i_ff[IW-1:0];
      st_wdata = b_ff;
      if (cmd.load_wr && (count_ff < CW'(CAPACITY))) begin
         st_we    = 1'b1;
         st_waddr = count_ff[IW-1:0];
         st_wdata = req_value;
      end else if (cmd.wr_swap_i) begin
         st_we    = 1'b1;
      end else if (cmd.wr_swap_j) begin
         st_we    = 1'b1;
         st_waddr = j_ff[IW-1:0];
         st_wdata = a_ff;
      end else if (cmd.fin_wr_low) begin
         st_we    = 1'b1;
         st_waddr = lo_ff;
         st_wdata = st_rdata;
      end else if (cmd.fin_wr_j) begin
         st_we    = 1'b1;
         st_waddr = j_ff[IW-1:0];
         st_wdata = pivot_ff;
      end

      if (cmd.pop_take) begin
         st_raddr = sk_rdata[2*IW-1:IW];
      end else if (cmd.rd_j) begin
         st_raddr = j_ff[IW-1:0];
      end else if (cmd.rd_k) begin
         st_raddr = k_ff[IW-1:0];
      end else begin
         st_raddr = i_ff[IW-1:0];
      end

      sk_raddr = sp_m1[SAW-1:0];
      sk_waddr = sp_ff[SAW-1:0];
      sk_we    = 1'b0;
      sk_wdata = {j_p1[IW-1:0], hi_ff};
      if (cmd.sort_init) begin
         sk_we    = 1'b1;
         sk_waddr = '0;
         sk_wdata = {{IW{1'b0}}, IW'(count_ff - CW'(1))};
      end else if (cmd.push_r) begin
         sk_we    = 1'b1;
      end else if (cmd.push_l) begin
         sk_we    = 1'b1;
         sk_wdata = {lo_ff, j_m1[IW-1:0]};
      end
   end

   always_comb begin
      count_in  = count_ff;
      k_in      = k_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pivot_in  = pivot_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cmp_in    = cmp_ff;
      mov_in    = mov_ff;
      sorted_in = sorted_ff;
      final_in  = final_ff;

      if (cmd.load_wr && (count_ff < CW'(CAPACITY))) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.sort_init) begin
         cmp_in = '0;
         mov_in = '0;
         sp_in  = SW'(1);
      end
      if (cmd.pop) begin
         sp_in = sp_m1;
      end
      if (cmd.pop_take) begin
         lo_in = sk_rdata[2*IW-1:IW];
         hi_in = sk_rdata[IW-1:0];
      end
      if (cmd.piv_take) begin
         pivot_in = st_rdata;
         i_in     = lo_s + PW'(1);
         j_in     = hi_s;
      end
      if (cmd.i_inc) begin
         i_in = i_ff + PW'(1);
      end
      if (cmd.j_dec) begin
         j_in = j_m1;
      end
      if (cmd.cmp_bump && (cmp_ff != CMP_MAX)) begin
         cmp_in = cmp_ff + CMP_W'(1);
      end
      if (cmd.mov_bump && (mov_ff != MOV_MAX)) begin
         mov_in = mov_ff + MOV_W'(1);
      end
      if (cmd.take_a) begin
         a_in = st_rdata;
      end
      if (cmd.take_b) begin
         b_in = st_rdata;
      end
      if (cmd.push_r || cmd.push_l) begin
         sp_in = sp_ff + SW'(1);
      end
      if (cmd.out_load) begin
         sorted_in = st_rdata;
         final_in  = (k_ff + CW'(1)) == count_ff;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         sp_in    = '0;
         k_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= '0;
         sp_ff    <= '0;
         cmp_ff   <= '0;
         mov_ff   <= '0;
      end else begin
         count_ff <= count_in;
         k_ff     <= k_in;
         sp_ff    <= sp_in;
         cmp_ff   <= cmp_in;
         mov_ff   <= mov_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      pivot_ff  <= pivot_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      sorted_ff <= sorted_in;
      final_ff  <= final_in;
   end

   always_comb begin
      status.sp_zero   = (sp_ff == '0);
      status.i_le_j    = (i_ff <= j_ff);
      status.i_le_hi   = (i_ff <= hi_s);
      status.j_ge_lo   = (j_ff >= lo_s);
      status.le_pivot  = (st_rdata <= pivot_ff);
      status.i_lt_j    = (i_ff < j_ff);
      status.lo_lt_j   = (lo_s < j_ff);
      status.push_r_ok = (j_p1 <= hi_s) && (sp_ff < SW'(DEPTH));
      status.push_l_ok = (lo_s <= j_m1) && (sp_ff < SW'(DEPTH));
      status.final_out = final_ff;
   end

   assign rsp_sorted_value  = sorted_ff;
   assign rsp_compare_count = cmp_ff;
   assign rsp_move_count    = mov_ff;
   assign rsp_final_res     = final_ff;
endmodule

// ===== rtl/qs_ctrl.sv =====
// Controller of the quicksort block: load, partition sequencing and output.
// Depends on qs_pkg for the command and status structs.
module qs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  qs_pkg::status_type status,
   output qs_pkg::cmd_type    cmd
);
   import qs_pkg::*;

   localparam logic [4:0] S_LOAD   = 5'd0;
   localparam logic [4:0] S_INIT   = 5'd1;
   localparam logic [4:0] S_POP    = 5'd2;
   localparam logic [4:0] S_POP_W  = 5'd3;
   localparam logic [4:0] S_PIV_W  = 5'd4;
   localparam logic [4:0] S_LOOP   = 5'd5;
   localparam logic [4:0] S_LSCAN  = 5'd6;
   localparam logic [4:0] S_LCMP   = 5'd7;
   localparam logic [4:0] S_RSCAN  = 5'd8;
   localparam logic [4:0] S_RCMP   = 5'd9;
   localparam logic [4:0] S_SWAP   = 5'd10;
   localparam logic [4:0] S_SWAP2  = 5'd11;
   localparam logic [4:0] S_FINAL  = 5'd12;
   localparam logic [4:0] S_FIN_W  = 5'd13;
   localparam logic [4:0] S_FIN2   = 5'd14;
   localparam logic [4:0] S_PUSH_R = 5'd15;
   localparam logic [4:0] S_PUSH_L = 5'd16;
   localparam logic [4:0] S_OUT_RD = 5'd17;
   localparam logic [4:0] S_OUT_W  = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   logic [4:0] state_ff, state_in;

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load_wr = 1'b1;
               if (req_last) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.sort_init = 1'b1;
            state_in      = S_POP;
         end
         S_POP: begin
            if (status.sp_zero) begin
               state_in = S_OUT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POP_W;
            end
         end
         S_POP_W: begin
            cmd.pop_take = 1'b1;
            state_in     = S_PIV_W;
         end
         S_PIV_W: begin
            cmd.piv_take = 1'b1;
            state_in     = S_LOOP;
         end
         S_LOOP: begin
            state_in = status.i_le_j ? S_LSCAN : S_FINAL;
         end
         S_LSCAN: begin
            if (status.i_le_hi) begin
               state_in = S_LCMP;
            end else begin
               cmd.cmp_bump = 1'b1;
               state_in     = S_RSCAN;
            end
         end
         S_LCMP: begin
            cmd.cmp_bump = 1'b1;
            if (status.le_pivot) begin
               cmd.i_inc = 1'b1;
               state_in  = S_LSCAN;
            end else begin
               cmd.take_a = 1'b1;
               state_in   = S_RSCAN;
            end
         end
         S_RSCAN: begin
            if (status.j_ge_lo) begin
               cmd.rd_j = 1'b1;
               state_in = S_RCMP;
            end else begin
               cmd.cmp_bump = 1'b1;
               state_in     = S_SWAP;
            end
         end
         S_RCMP: begin
            cmd.cmp_bump = 1'b1;
            if (!status.le_pivot) begin
               cmd.j_dec = 1'b1;
               state_in  = S_RSCAN;
            end else begin
               cmd.take_b = 1'b1;
               state_in   = S_SWAP;
            end
         end
         S_SWAP: begin
            if (status.i_lt_j) begin
               cmd.wr_swap_i = 1'b1;
               state_in      = S_SWAP2;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_SWAP2: begin
            cmd.wr_swap_j = 1'b1;
            cmd.mov_bump  = 1'b1;
            state_in      = S_LOOP;
         end
         S_FINAL: begin
            if (status.lo_lt_j) begin
               cmd.rd_j = 1'b1;
               state_in = S_FIN_W;
            end else begin
               state_in = S_PUSH_R;
            end
         end
         S_FIN_W: begin
            cmd.fin_wr_low = 1'b1;
            state_in       = S_FIN2;
         end
         S_FIN2: begin
            cmd.fin_wr_j = 1'b1;
            cmd.mov_bump = 1'b1;
            state_in     = S_PUSH_R;
         end
         S_PUSH_R: begin
            cmd.push_r = status.push_r_ok;
            state_in   = S_PUSH_L;
         end
         S_PUSH_L: begin
            cmd.push_l = status.push_l_ok;
            state_in   = S_POP;
         end
         S_OUT_RD: begin
            cmd.rd_k = 1'b1;
            state_in = S_OUT_W;
         end
         S_OUT_W: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (status.final_out) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/quicksort_with_op_counts.sv =====
// Top level of the quicksort block: request and response channels,
// controller and datapath. Depends on qs_pkg, qs_chan_if, qs_ctrl, qs_dp.
//
// Values arrive one per transaction into a store of CAPACITY entries;
// transactions beyond it are dropped. The transaction marked last starts an
// in-place quicksort (first element pivot, explicit range stack) that counts
// comparisons and swaps, both saturating. The sort is paced by the single
// read port of the element store. Results then leave in ascending order,
// one store read per result and held by any response stall, the last one
// flagged with final_res; no request is taken until the last is delivered.
module quicksort_with_op_counts #(
   parameter int CAPACITY = qs_pkg::CAPACITY_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   qs_req_if.sink  req_ch,
   qs_rsp_if.source rsp_ch
);
   import qs_pkg::*;

   cmd_type    cmd;
   status_type status;

   qs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qs_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_ch.value),
      .rsp_sorted_value  (rsp_ch.sorted_value),
      .rsp_compare_count (rsp_ch.compare_count),
      .rsp_move_count    (rsp_ch.move_count),
      .rsp_final_res     (rsp_ch.final_res)
   );
endmodule

// ===== verif/quicksort_with_op_counts_tb_if.sv =====
// Testbench-side view of the quicksort channels: none needed beyond the RTL
// interfaces in qs_chan_if; this file holds shared testbench types. Depends on qs_pkg.
package qs_tb_pkg;
   typedef struct {
      logic signed [qs_pkg::VALUE_W-1:0] sorted_value;
      logic [qs_pkg::CMP_W-1:0]          compare_count;
      logic [qs_pkg::MOV_W-1:0]          move_count;
      logic                              final_res;
   } sorted_result_type;
endpackage

// ===== verif/quicksort_with_op_counts_tb.sv =====
// Testbench for quicksort_with_op_counts: drives value sets, predicts the
// sorted output and operation counts, and checks every response transaction.
// Depends on qs_pkg, qs_chan_if, qs_tb_pkg and the RTL.
module quicksort_with_op_counts_tb;
   import qs_pkg::*;
   import qs_tb_pkg::*;

   localparam int CAP = CAPACITY_DEFAULT;
   localparam int LIMIT = 2000000;

   int errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   class sort_scoreboard;
      logic signed [31:0] store[CAP];
      int fill;
      sorted_result_type pending[$];
      int sets, results;

      function void bump(ref int c, input int mx);
         if (c < mx) c++;
      endfunction

      function void note_input(logic signed [31:0] v, logic lst);
         int lo_q[$], hi_q[$];
         int lo, hi, i, j, cmp, mov;
         logic signed [31:0] piv, t;
         if (fill < CAP) begin
            store[fill] = v;
            fill++;
         end
         if (!lst) return;
         cmp = 0; mov = 0;
         if (fill > 0) begin lo_q.push_back(0); hi_q.push_back(fill - 1); end
         while (lo_q.size() > 0) begin
            lo = lo_q.pop_back(); hi = hi_q.pop_back();
            piv = store[lo]; i = lo + 1; j = hi;
            while (i <= j) begin
               while (i <= hi && store[i] <= piv) begin i++; bump(cmp, 65535); end
               bump(cmp, 65535);
               while (j >= lo && store[j] > piv) begin j--; bump(cmp, 65535); end
               bump(cmp, 65535);
               if (i < j) begin
                  t = store[i]; store[i] = store[j]; store[j] = t;
                  bump(mov, 4095);
               end
            end
            if (lo < j) begin
               t = store[lo]; store[lo] = store[j]; store[j] = t;
               bump(mov, 4095);
            end
            if (j + 1 <= hi && lo_q.size() < CAP + 2) begin
               lo_q.push_back(j + 1); hi_q.push_back(hi);
            end
            if (lo <= j - 1 && lo_q.size() < CAP + 2) begin
               lo_q.push_back(lo); hi_q.push_back(j - 1);
            end
         end
         for (int k = 0; k < fill; k++) begin
            sorted_result_type r;
            r.sorted_value = store[k];
            r.compare_count = cmp[15:0];
            r.move_count = mov[11:0];
            r.final_res = (k == fill - 1);
            pending.push_back(r);
         end
         fill = 0;
         sets++;
      endfunction

      task check_result(sorted_result_type r);
         sorted_result_type e;
         results++;
         if (pending.size() == 0) begin
            report("unexpected transaction", r.sorted_value, 0);
            return;
         end
         e = pending.pop_front();
         if (r.sorted_value !== e.sorted_value)
            report("sorted_value", r.sorted_value, e.sorted_value);
         if (r.compare_count !== e.compare_count)
            report("compare_count", r.compare_count, e.compare_count);
         if (r.move_count !== e.move_count)
            report("move_count", r.move_count, e.move_count);
         if (r.final_res !== e.final_res)
            report("final_res", r.final_res, e.final_res);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   qs_req_if req_ch();
   qs_rsp_if rsp_ch();
   sort_scoreboard sb = new();
   int cycle = 0;
   bit quiet = 0;
   int sent = 0;

   quicksort_with_op_counts dut (.clock(clock), .reset(reset),
      .req_ch(req_ch), .rsp_ch(rsp_ch));

   initial forever #5 clock = ~clock;

   initial begin
      req_ch.valid = 0; req_ch.value = 0; req_ch.last = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sorted_result_type r;
         r.sorted_value = rsp_ch.sorted_value;
         r.compare_count = rsp_ch.compare_count;
         r.move_count = rsp_ch.move_count;
         r.final_res = rsp_ch.final_res;
         sb.check_result(r);
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 26);

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send(input logic signed [31:0] v, input logic lst);
      while (!quiet && $urandom_range(99) < 26) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1; req_ch.value <= v; req_ch.last <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_input(v, lst);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rnd_value(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(8)) - 4;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(2000)) - 1000;
      endcase
   endfunction

   initial begin
      int n, mode;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(32'sh7fffffff, 1'b1);
      send(32'sh80000000, 1'b0); send(0, 1'b0); send(-1, 1'b0);
      send(32'sh7fffffff, 1'b1);
      send(5, 1'b0); send(5, 1'b0); send(5, 1'b1);
      for (int k = 0; k < 4; k++) send(k, k == 3);
      for (int k = 0; k < 4; k++) send(10 - k, k == 3);
      drain();
      for (int k = 0; k < CAP + 3; k++) send(CAP - k, k == CAP + 2);
      drain();
      while (sent < 250) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(CAP + 4, 20) : $urandom_range(10, 1);
         mode = $urandom_range(3);
         quiet = (sent > 130 && sent < 180);
         for (int k = 0; k < n; k++) send(rnd_value(mode), k == n - 1);
         if ($urandom_range(7) == 0) drain();
      end
      quiet = 0;
      send($urandom, 1'b0);
      send($urandom, 1'b1);
      drain();
      $display("covered %0d request transactions in %0d sets, %0d results checked",
         sent, sb.sets, sb.results);
      if (errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/qs_pkg.sv
rtl/qs_chan_if.sv
rtl/qs_ram.sv
rtl/qs_dp.sv
rtl/qs_ctrl.sv
rtl/quicksort_with_op_counts.sv
verif/quicksort_with_op_counts_tb_if.sv
verif/quicksort_with_op_counts_tb.sv
